@@ design/bfa_pkg.sv @@
// Shared codes for the bitmap frame allocator.
package bfa_pkg;

    localparam logic [1:0] KIND_ALLOC      = 2'd0;
    localparam logic [1:0] KIND_FREE       = 2'd1;
    localparam logic [1:0] KIND_RANGE_FREE = 2'd2;
    localparam logic [1:0] KIND_RANGE_USED = 2'd3;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_OOM     = 2'd1;
    localparam logic [1:0] STATUS_IGNORED = 2'd2;

    localparam int ADDR_W   = 48;
    localparam int COUNT_W  = 16;
    // address + length + FRAME_BYTES - 1 needs two bits above the address
    localparam int NUM_W    = 50;

endpackage

@@ design/bfa_front.sv @@
// Front end: accepts beats, turns byte addresses into frame and word positions.
module bfa_front #(
    parameter int MAX_FRAMES    = 32768,
    parameter int FRAME_BYTES   = 4096,
    parameter int FW            = 16,
    parameter int WAW           = 9,
    parameter int BW            = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  kind,
    input  logic [bfa_pkg::ADDR_W-1:0]  address,
    input  logic [bfa_pkg::ADDR_W-1:0]  length,
    input  logic                        clearing,
    output logic                        push,
    input  logic                        q_full,
    output logic [1:0]                  cmd_kind,
    output logic [WAW-1:0]              cmd_word,
    output logic [BW-1:0]               cmd_bit,
    output logic [FW-1:0]               cmd_count
);
    import bfa_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CALC = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    localparam int               FB_SH = $clog2(FRAME_BYTES);
    localparam logic [FW-1:0]    MAX_F = FW'(MAX_FRAMES);
    localparam logic [NUM_W-1:0] MAX_N = NUM_W'(MAX_FRAMES);

    logic [1:0]        state_reg, state_next;
    logic [1:0]        kind_reg;
    logic [NUM_W-1:0]  addr_reg;
    logic [NUM_W-1:0]  sum_reg;
    logic [WAW-1:0]    word_reg;
    logic [BW-1:0]     bit_reg;
    logic [FW-1:0]     n_reg;

    logic              accept;
    logic [NUM_W-1:0]  sum_in;
    logic [NUM_W-1:0]  start_q, end_q;
    logic [FW-1:0]     s_clip, e_clip, e_free, e_sel;

    assign in_stall = (state_reg != F_IDLE) || clearing;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        sum_in = NUM_W'(address) + NUM_W'(length);
        if (kind == KIND_RANGE_USED)
        begin
            sum_in = sum_in + NUM_W'(FRAME_BYTES - 1);
        end
    end

    // page and word sizes are powers of two, so frame numbers are shifts
    assign start_q = addr_reg >> FB_SH;
    assign end_q   = sum_reg >> FB_SH;
    assign s_clip  = (start_q >= MAX_N) ? MAX_F : start_q[FW-1:0];
    assign e_clip  = (end_q >= MAX_N) ? MAX_F : end_q[FW-1:0];
    // single free: one frame unless the start is off the map
    assign e_free  = (s_clip < MAX_F) ? s_clip + FW'(1) : s_clip;
    assign e_sel   = (kind_reg == KIND_FREE) ? e_free : e_clip;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = (kind == KIND_ALLOC) ? F_PUSH : F_CALC;
                end
            end
            F_CALC:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            addr_reg <= NUM_W'(address);
            sum_reg  <= sum_in;
            n_reg    <= '0;
        end
        if (state_reg == F_CALC)
        begin
            word_reg <= s_clip[BW +: WAW];
            bit_reg  <= s_clip[BW-1:0];
            n_reg    <= (e_sel > s_clip) ? e_sel - s_clip : '0;
        end
    end

    assign push      = (state_reg == F_PUSH) && !q_full;
    assign cmd_kind  = kind_reg;
    assign cmd_word  = word_reg;
    assign cmd_bit   = bit_reg;
    assign cmd_count = n_reg;

endmodule

@@ design/bfa_queue.sv @@
// Two-entry command queue between front and back end.
module bfa_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       fill_reg;

    assign full      = fill_reg == 2'd2;
    assign not_empty = fill_reg != 2'd0;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/bfa_back.sv @@
// Back end: bitmap memory, word scan and range marking, result register.
module bfa_back #(
    parameter int MAX_FRAMES    = 32768,
    parameter int FRAME_BYTES   = 4096,
    parameter int MAP_WORD_BITS = 64,
    parameter int MAP_WORDS     = 512,
    parameter int FW            = 16,
    parameter int WAW           = 9,
    parameter int BW            = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    output logic                         clearing,
    input  logic                         q_not_empty,
    output logic                         pop,
    input  logic [1:0]                   cmd_kind,
    input  logic [WAW-1:0]               cmd_word,
    input  logic [BW-1:0]                cmd_bit,
    input  logic [FW-1:0]                cmd_count,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bfa_pkg::ADDR_W-1:0]   frame_address,
    output logic [1:0]                   status,
    output logic [bfa_pkg::COUNT_W-1:0]  free_count
);
    import bfa_pkg::*;

    localparam int RW = FW + 1;
    localparam int PW = $clog2(MAP_WORD_BITS + 1);
    localparam int MW = FW + 17;
    localparam int FB_SH = $clog2(FRAME_BYTES);
    localparam logic [WAW-1:0] LAST_WORD = WAW'(MAP_WORDS - 1);
    localparam logic [RW-1:0]  MWB_R     = RW'(MAP_WORD_BITS);

    localparam logic [3:0] B_CLR  = 4'd0;
    localparam logic [3:0] B_IDLE = 4'd1;
    localparam logic [3:0] B_ARD  = 4'd2;
    localparam logic [3:0] B_AEV  = 4'd3;
    localparam logic [3:0] B_AMUL = 4'd4;
    localparam logic [3:0] B_RRD  = 4'd5;
    localparam logic [3:0] B_RMOD = 4'd6;
    localparam logic [3:0] B_RCNT = 4'd7;
    localparam logic [3:0] B_OUT  = 4'd8;

    logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [MAP_WORD_BITS-1:0] rd_data;

    logic [3:0]           state_reg;
    logic [WAW-1:0]       w_reg;
    logic [1:0]           kind_reg;
    logic [BW-1:0]        bit0_reg;
    logic [RW-1:0]        rem_reg;
    logic [RW-1:0]        base_reg;
    logic [FW-1:0]        cnt_reg;
    logic [PW-1:0]        pop_reg;
    logic                 chg_any_reg;
    logic [FW-1:0]        f_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [1:0]           status_reg;
    logic                 ovalid_reg;

    logic                     we;
    logic [WAW-1:0]           ra, wa;
    logic [MAP_WORD_BITS-1:0] wd;
    logic [BW-1:0]            zero_bit;
    logic                     word_full;
    logic [MAP_WORD_BITS-1:0] mask, changed, mod_word;
    logic [PW-1:0]            pop_cnt;
    logic [MW-1:0]            prod;
    logic [31:0]              cnt32;
    logic                     any_now;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            map_mem[wa] <= wd;
        end
        rd_data <= map_mem[ra];
    end

    // lowest clear bit of the scanned word
    always_comb
    begin
        zero_bit  = '0;
        word_full = &rd_data;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--)
        begin
            if (!rd_data[i])
            begin
                zero_bit = BW'(i);
            end
        end
    end

    always_comb
    begin
        pop_cnt = '0;
        for (int i = 0; i < MAP_WORD_BITS; i++)
        begin
            mask[i] = (RW'(i) < rem_reg) && (RW'(i) >= RW'(bit0_reg));
        end
        if (kind_reg == KIND_RANGE_USED)
        begin
            changed  = ~rd_data & mask;
            mod_word = rd_data | mask;
        end
        else
        begin
            changed  = rd_data & mask;
            mod_word = rd_data & ~mask;
        end
        for (int i = 0; i < MAP_WORD_BITS; i++)
        begin
            pop_cnt = pop_cnt + PW'(changed[i]);
        end
    end

    always_comb
    begin
        we = 1'b0;
        wa = w_reg;
        wd = mod_word;
        ra = w_reg;
        unique case (state_reg)
            B_CLR:
            begin
                we = 1'b1;
                wd = '1;
            end
            B_AEV:
            begin
                we = !word_full;
                wd = rd_data | (MAP_WORD_BITS'(1) << zero_bit);
            end
            B_RMOD:
            begin
                we = 1'b1;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    assign prod     = MW'(f_reg) << FB_SH;
    assign any_now  = chg_any_reg || (pop_reg != '0);
    assign clearing = state_reg == B_CLR;
    assign pop      = (state_reg == B_IDLE) && q_not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_CLR;
            w_reg      <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_CLR:
                begin
                    w_reg <= w_reg + WAW'(1);
                    if (w_reg == LAST_WORD)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    if (q_not_empty)
                    begin
                        if (cmd_kind == KIND_ALLOC)
                        begin
                            w_reg     <= '0;
                            state_reg <= B_ARD;
                        end
                        else if (cmd_count == '0)
                        begin
                            ovalid_reg <= 1'b1;
                            state_reg  <= B_OUT;
                        end
                        else
                        begin
                            w_reg     <= cmd_word;
                            state_reg <= B_RRD;
                        end
                    end
                end
                B_ARD:
                begin
                    state_reg <= B_AEV;
                end
                B_AEV:
                begin
                    if (!word_full)
                    begin
                        if (cnt_reg != '0)
                        begin
                            cnt_reg <= cnt_reg - FW'(1);
                        end
                        state_reg <= B_AMUL;
                    end
                    else if (w_reg == LAST_WORD)
                    begin
                        ovalid_reg <= 1'b1;
                        state_reg  <= B_OUT;
                    end
                    else
                    begin
                        w_reg     <= w_reg + WAW'(1);
                        state_reg <= B_ARD;
                    end
                end
                B_AMUL:
                begin
                    ovalid_reg <= 1'b1;
                    state_reg  <= B_OUT;
                end
                B_RRD:
                begin
                    state_reg <= B_RMOD;
                end
                B_RMOD:
                begin
                    state_reg <= B_RCNT;
                end
                B_RCNT:
                begin
                    if (kind_reg == KIND_RANGE_USED)
                    begin
                        cnt_reg <= (cnt_reg >= FW'(pop_reg)) ? cnt_reg - FW'(pop_reg) : '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + FW'(pop_reg);
                    end
                    if (rem_reg <= MWB_R)
                    begin
                        ovalid_reg <= 1'b1;
                        state_reg  <= B_OUT;
                    end
                    else
                    begin
                        w_reg     <= w_reg + WAW'(1);
                        state_reg <= B_RRD;
                    end
                end
                B_OUT:
                begin
                    if (!out_stall)
                    begin
                        ovalid_reg <= 1'b0;
                        state_reg  <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                kind_reg    <= cmd_kind;
                bit0_reg    <= cmd_bit;
                rem_reg     <= RW'(cmd_count) + RW'(cmd_bit);
                base_reg    <= '0;
                chg_any_reg <= 1'b0;
                addr_reg    <= '0;
                status_reg  <= (cmd_kind == KIND_FREE) ? STATUS_IGNORED : STATUS_DONE;
            end
            B_AEV:
            begin
                f_reg    <= FW'(base_reg + RW'(zero_bit));
                base_reg <= base_reg + MWB_R;
                if (word_full && w_reg == LAST_WORD)
                begin
                    status_reg <= STATUS_OOM;
                end
            end
            B_AMUL:
            begin
                addr_reg   <= ADDR_W'(prod);
                status_reg <= STATUS_DONE;
            end
            B_RMOD:
            begin
                pop_reg <= pop_cnt;
            end
            B_RCNT:
            begin
                chg_any_reg <= any_now;
                rem_reg     <= rem_reg - MWB_R;
                bit0_reg    <= '0;
                if (kind_reg == KIND_FREE)
                begin
                    status_reg <= any_now ? STATUS_DONE : STATUS_IGNORED;
                end
            end
            default:
            begin
                pop_reg <= pop_reg;
            end
        endcase
    end

    assign cnt32         = 32'(cnt_reg);
    assign out_valid     = ovalid_reg;
    assign frame_address = addr_reg;
    assign status        = status_reg;
    assign free_count    = (cnt32 > 32'd65535) ? 16'hFFFF : cnt32[15:0];

endmodule

@@ design/bitmap_frame_allocator.sv @@
// Top level of the first-fit bitmap frame allocator.
// Usage: one request beat (kind, address, length) on the in channel gives
// exactly one result beat (frame_address, status, free_count) on the out
// channel, in order. Both channels use valid/stall.
// FRAME_BYTES and MAP_WORD_BITS must be powers of two; the block does not
// check this. The front end turns byte addresses into frame, word and bit
// positions by shifts (not for allocate) and pushes a command into a
// two-entry queue, so it can take the next request while the back end still
// works on the previous one. The back end walks the bitmap memory one word
// at a time through one read port and one write port: allocate reads and then
// checks each scanned word, free and range requests read, modify and count
// each touched word; a free or range request touching no frame skips the walk.
// The back end takes the next queued command in the cycle after its result
// beat is accepted.
// After reset all frames are used and the free count is zero; the back end
// first writes every map word (512 by default) to all ones, during which
// in_stall is high. A stalled result holds in the output register; the front
// keeps accepting until the queue fills, then stalls.
module bitmap_frame_allocator #(
    parameter int MAX_FRAMES    = 32768,
    parameter int FRAME_BYTES   = 4096,
    parameter int MAP_WORD_BITS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   kind,
    input  logic [bfa_pkg::ADDR_W-1:0]   address,
    input  logic [bfa_pkg::ADDR_W-1:0]   length,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bfa_pkg::ADDR_W-1:0]   frame_address,
    output logic [1:0]                   status,
    output logic [bfa_pkg::COUNT_W-1:0]  free_count
);
    import bfa_pkg::*;

    localparam int MAP_WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int FW        = $clog2(MAX_FRAMES + 1);
    localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(MAP_WORD_BITS);
    localparam int CMD_W     = 2 + WAW + BW + FW;

    logic             clearing, push, q_full, q_not_empty, pop;
    logic [1:0]       f_kind, b_kind;
    logic [WAW-1:0]   f_word, b_word;
    logic [BW-1:0]    f_bit, b_bit;
    logic [FW-1:0]    f_count, b_count;
    logic [CMD_W-1:0] q_in, q_out;

    bfa_front #(
        .MAX_FRAMES    (MAX_FRAMES),
        .FRAME_BYTES   (FRAME_BYTES),
        .FW            (FW),
        .WAW           (WAW),
        .BW            (BW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .address   (address),
        .length    (length),
        .clearing  (clearing),
        .push      (push),
        .q_full    (q_full),
        .cmd_kind  (f_kind),
        .cmd_word  (f_word),
        .cmd_bit   (f_bit),
        .cmd_count (f_count)
    );

    assign q_in = {f_kind, f_word, f_bit, f_count};

    bfa_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    assign {b_kind, b_word, b_bit, b_count} = q_out;

    bfa_back #(
        .MAX_FRAMES    (MAX_FRAMES),
        .FRAME_BYTES   (FRAME_BYTES),
        .MAP_WORD_BITS (MAP_WORD_BITS),
        .MAP_WORDS     (MAP_WORDS),
        .FW            (FW),
        .WAW           (WAW),
        .BW            (BW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .clearing      (clearing),
        .q_not_empty   (q_not_empty),
        .pop           (pop),
        .cmd_kind      (b_kind),
        .cmd_word      (b_word),
        .cmd_bit       (b_bit),
        .cmd_count     (b_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_address (frame_address),
        .status        (status),
        .free_count    (free_count)
    );

endmodule

@@ design/bfa_checker.sv @@
// Port-level checks for the frame allocator, bound to the top level.
module bfa_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [bfa_pkg::ADDR_W-1:0]   frame_address,
    input  logic [1:0]                   status,
    input  logic [bfa_pkg::COUNT_W-1:0]  free_count
);
    import bfa_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_address))
        else $error("result beat dropped while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_DONE || status == STATUS_OOM ||
                       status == STATUS_IGNORED))
        else $error("unknown status code");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_DONE |-> frame_address == '0)
        else $error("nonzero address on failed request");

    a_oom_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_OOM |-> free_count == '0)
        else $error("out of memory with free frames counted");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_address (frame_address),
    .status        (status),
    .free_count    (free_count)
);
